// ===== rtl/htw_pkg.sv =====
// Shared constants, codes and the timer entry type for the timing wheel.
package htw_pkg;

  localparam int ID_W        = 5;
  localparam int TIMERS      = 1 << ID_W;
  localparam int SLOT_W      = 6;
  localparam int WHEEL_SLOTS = 1 << SLOT_W;
  localparam int TO_W        = 24;
  localparam int MAG_W       = TO_W - 1;
  localparam int TURNS_W     = MAG_W - SLOT_W;
  localparam int TS_W        = 12;
  localparam int CNT_W       = $clog2(MAG_W + 1);
  localparam int OP_W        = 2;
  localparam int KIND_W      = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_ADJUST = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

  localparam logic [KIND_W-1:0] K_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] K_REMOVE  = 3'd1;
  localparam logic [KIND_W-1:0] K_ADJUST  = 3'd2;
  localparam logic [KIND_W-1:0] K_EXPIRED = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE    = 3'd4;

  localparam logic [TS_W-1:0] TICK_RESET = 12'd1;

  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic [TURNS_W-1:0] turns;
  } entry_t;

endpackage

// ===== rtl/htw_cell.sv =====
// One timer entry of the rotating ring; takes its neighbor's entry on each shift.
module htw_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  htw_pkg::entry_t d,
  output htw_pkg::entry_t q
);
  import htw_pkg::*;

  // only the valid bit is reset; slot and turns are read only behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
    if (shift) begin
      q.slot  <= d.slot;
      q.turns <= d.turns;
    end
  end

endmodule

// ===== rtl/htw_div.sv =====
// Restoring divider, one quotient bit per cycle: timeout over tick length.
module htw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [htw_pkg::MAG_W-1:0] dividend,
  input  logic [htw_pkg::TS_W-1:0]  divisor,
  output logic                      busy,
  output logic [htw_pkg::MAG_W-1:0] quot
);
  import htw_pkg::*;

  logic [TS_W-1:0]  rem;
  logic [TS_W-1:0]  dsr;
  logic [CNT_W-1:0] cnt;
  logic [TS_W:0]    shifted;
  logic [TS_W-1:0]  diff;
  logic             ge;

  // remainder stays below the divisor, so the difference fits TS_W bits
  assign shifted = {rem, quot[MAG_W-1]};
  assign ge      = (shifted >= {1'b0, dsr});
  assign diff    = shifted[TS_W-1:0] - dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(MAG_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff : shifted[TS_W-1:0];
      quot <= {quot[MAG_W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

// ===== rtl/hashed_timing_wheel_unit.sv =====
// Hashed timing wheel: 32 timer entries in a rotating ring of cells, processed at the head.
// Remove and tick scan the whole ring once; a tick scan waits while an output stall holds back an expired word.
// Insert and adjust run the divide before the scan; a negative timeout skips both and goes straight to the reply.
// One word at a time; a finished reply may wait in the output register meanwhile.
// Synchronous reset clears all valid bits and the wheel position, tick length back to 1.
module hashed_timing_wheel_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [htw_pkg::TS_W-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [htw_pkg::OP_W-1:0]         operation,
  input  logic [htw_pkg::ID_W-1:0]         timer_id,
  input  logic signed [htw_pkg::TO_W-1:0]  timeout_seconds,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [htw_pkg::KIND_W-1:0]       kind,
  output logic                             status,
  output logic [htw_pkg::ID_W-1:0]         handle,
  output logic                             last
);
  import htw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_REPLY = 2'd3;

  logic [1:0]        state;
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   hand_r;
  logic [ID_W-1:0]   scan_cnt;
  logic              ok_r;
  logic [SLOT_W-1:0] cur_slot;
  logic [TS_W-1:0]   tick_len;

  logic              in_acc;
  logic              out_free;
  logic              step;
  logic              emit;
  logic              ok_set;
  logic              div_start;
  logic              div_busy;
  logic [MAG_W-1:0]  div_quot;
  logic [TS_W-1:0]   divisor;
  logic              is_short;
  logic [SLOT_W-1:0] new_slot;
  logic [TURNS_W-1:0] new_turns;
  entry_t            head_next;
  entry_t            cell_d [TIMERS];
  entry_t            cell_q [TIMERS];
  logic [KIND_W-1:0] reply_kind;

  assign in_stall = rst || (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_len <= TICK_RESET;
    end else if (cfg_write) begin
      tick_len <= cfg_data;
    end
  end

  // zero tick length counts as one second
  assign divisor   = (tick_len == '0) ? TS_W'(1) : tick_len;
  assign div_start = in_acc && (operation == OP_INSERT || operation == OP_ADJUST)
                     && !timeout_seconds[TO_W-1];

  htw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (timeout_seconds[MAG_W-1:0]),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  // sub-tick timeouts land in the next slot
  assign is_short  = (div_quot == '0);
  assign new_slot  = is_short ? cur_slot + 1'b1 : cur_slot + div_quot[SLOT_W-1:0];
  assign new_turns = is_short ? '0 : div_quot[MAG_W-1:SLOT_W];

  // head cell update; head holds handle scan_cnt
  always_comb begin
    head_next = cell_q[0];
    emit      = 1'b0;
    ok_set    = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (!ok_r && !cell_q[0].valid) begin
          head_next.valid = 1'b1;
          head_next.slot  = new_slot;
          head_next.turns = new_turns;
          ok_set          = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (scan_cnt == id_r && cell_q[0].valid) begin
          head_next.valid = 1'b0;
          ok_set          = 1'b1;
        end
      end
      OP_ADJUST: begin
        if (scan_cnt == id_r && cell_q[0].valid) begin
          head_next.slot  = new_slot;
          head_next.turns = new_turns;
          ok_set          = 1'b1;
        end
      end
      OP_TICK: begin
        if (cell_q[0].valid && cell_q[0].slot == cur_slot) begin
          if (cell_q[0].turns != '0) begin
            head_next.turns = cell_q[0].turns - 1'b1;
          end else begin
            head_next.valid = 1'b0;
            emit            = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign step = (state == ST_SCAN) && (!emit || out_free);

  genvar k;
  generate
    for (k = 0; k < TIMERS; k++) begin : g_cell
      if (k == TIMERS - 1) begin : g_tail
        assign cell_d[k] = head_next;
      end else begin : g_link
        assign cell_d[k] = cell_q[k+1];
      end
      htw_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (step),
        .d     (cell_d[k]),
        .q     (cell_q[k])
      );
    end
  endgenerate

  always_comb begin
    unique case (op_r)
      OP_INSERT: reply_kind = K_INSERT;
      OP_REMOVE: reply_kind = K_REMOVE;
      OP_ADJUST: reply_kind = K_ADJUST;
      OP_TICK:   reply_kind = K_DONE;
      default:   reply_kind = K_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_slot <= '0;
      ok_r     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            ok_r <= 1'b0;
            if (operation == OP_INSERT || operation == OP_ADJUST) begin
              state <= timeout_seconds[TO_W-1] ? ST_REPLY : ST_DIV;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (ok_set) begin
              ok_r <= 1'b1;
            end
            if (scan_cnt == ID_W'(TIMERS - 1)) begin
              state <= ST_REPLY;
            end
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (op_r == OP_TICK) begin
              cur_slot <= cur_slot + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= operation;
      id_r     <= timer_id;
      hand_r   <= '0;
      scan_cnt <= '0;
    end else if (step) begin
      scan_cnt <= scan_cnt + 1'b1;
      if (ok_set && op_r == OP_INSERT) begin
        hand_r <= scan_cnt;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((step && emit) || (state == ST_REPLY && out_free)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind   <= K_EXPIRED;
      status <= 1'b0;
      handle <= scan_cnt;
      last   <= 1'b0;
    end else if (state == ST_REPLY && out_free) begin
      kind   <= reply_kind;
      status <= (op_r == OP_TICK) ? 1'b0 : !ok_r;
      last   <= 1'b1;
      if (op_r == OP_TICK) begin
        handle <= '0;
      end else if (op_r == OP_INSERT) begin
        handle <= ok_r ? hand_r : '0;
      end else begin
        handle <= id_r;
      end
    end
  end

endmodule

// ===== rtl/htw_check.sv =====
// Port-level checks for the timing wheel, bound to the top level.
module htw_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [htw_pkg::KIND_W-1:0]       kind,
  input logic                             status,
  input logic [htw_pkg::ID_W-1:0]         handle,
  input logic                             last
);
  import htw_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
      && $stable(handle) && $stable(last))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_done_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_DONE |-> last && !status && handle == '0)
    else $error("malformed tick done word");

  a_expired_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_EXPIRED |-> !last && !status)
    else $error("malformed expired word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the reply");

endmodule

bind hashed_timing_wheel_unit htw_check u_htw_check (.*);

// ===== test/hashed_timing_wheel_unit_tb.sv =====
// Testbench for the hashed timing wheel: directed table, then random words checked by a predictor.
module hashed_timing_wheel_unit_tb;
  import htw_pkg::*;

  localparam int DIR_ROWS    = 19;
  localparam int ROUND_WORDS = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [ID_W-1:0]   handle;
    logic              last;
  } reply_t;

  // one input word; typed rows carry their single reply written out by hand
  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [ID_W-1:0]        id;
    logic signed [TO_W-1:0] secs;
    logic                   typed;
    reply_t                 reply;
  } word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [TS_W-1:0]        cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        operation;
  logic [ID_W-1:0]        timer_id;
  logic signed [TO_W-1:0] timeout_seconds;
  logic                   out_valid;
  logic                   out_stall;
  logic [KIND_W-1:0]      kind;
  logic                   status;
  logic [ID_W-1:0]        handle;
  logic                   last;

  // predictor state
  bit                 live [TIMERS];
  logic [SLOT_W-1:0]  slot_of [TIMERS];
  logic [TURNS_W-1:0] turns_of [TIMERS];
  logic [SLOT_W-1:0]  wheel_pos;
  logic [TS_W-1:0]    tick_len;

  reply_t due_replies [$];
  int     fault_count;
  int     send_idle;
  int     recv_idle;

  word_t dir_table [0:DIR_ROWS-1] = '{
    '{OP_REMOVE, 5'd0,  24'sd0,        1'b1, '{K_REMOVE, 1'b1, 5'd0,  1'b1}},
    '{OP_ADJUST, 5'd31, 24'sd5,        1'b1, '{K_ADJUST, 1'b1, 5'd31, 1'b1}},
    '{OP_INSERT, 5'd0,  24'shFFFFFF,   1'b1, '{K_INSERT, 1'b1, 5'd0,  1'b1}},
    '{OP_INSERT, 5'd0,  24'sh800000,   1'b1, '{K_INSERT, 1'b1, 5'd0,  1'b1}},
    '{OP_INSERT, 5'd0,  24'sd0,        1'b1, '{K_INSERT, 1'b0, 5'd0,  1'b1}},
    '{OP_INSERT, 5'd0,  24'sh7FFFFF,   1'b1, '{K_INSERT, 1'b0, 5'd1,  1'b1}},
    '{OP_INSERT, 5'd0,  24'sd64,       1'b1, '{K_INSERT, 1'b0, 5'd2,  1'b1}},
    '{OP_TICK,   5'd0,  24'sd0,        1'b1, '{K_DONE,   1'b0, 5'd0,  1'b1}},
    '{OP_TICK,   5'd0,  24'sd0,        1'b0, '0},
    '{OP_ADJUST, 5'd1,  24'sd1,        1'b1, '{K_ADJUST, 1'b0, 5'd1,  1'b1}},
    '{OP_ADJUST, 5'd2,  -24'sd5,       1'b1, '{K_ADJUST, 1'b1, 5'd2,  1'b1}},
    '{OP_REMOVE, 5'd1,  24'sd0,        1'b1, '{K_REMOVE, 1'b0, 5'd1,  1'b1}},
    '{OP_REMOVE, 5'd1,  24'sd0,        1'b1, '{K_REMOVE, 1'b1, 5'd1,  1'b1}},
    '{OP_INSERT, 5'd0,  24'sd2,        1'b1, '{K_INSERT, 1'b0, 5'd0,  1'b1}},
    '{OP_REMOVE, 5'd31, 24'sd0,        1'b1, '{K_REMOVE, 1'b1, 5'd31, 1'b1}},
    '{OP_TICK,   5'd0,  24'sd0,        1'b0, '0},
    '{OP_TICK,   5'd0,  24'sd0,        1'b0, '0},
    '{OP_TICK,   5'd0,  24'sd0,        1'b0, '0},
    '{OP_INSERT, 5'd0,  24'sh7FFFFF,   1'b0, '0}
  };

  hashed_timing_wheel_unit uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .timer_id        (timer_id),
    .timeout_seconds (timeout_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .status          (status),
    .handle          (handle),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  // slot and turns for a timeout; zero when the timeout is negative
  function automatic bit place_timer(input logic signed [TO_W-1:0] secs,
                                     output logic [SLOT_W-1:0] slot,
                                     output logic [TURNS_W-1:0] turns);
    logic [TS_W-1:0]  len;
    logic [MAG_W-1:0] ticks;
    len = (tick_len == '0) ? TS_W'(1) : tick_len;
    slot = '0;
    turns = '0;
    if (secs[TO_W-1]) return 1'b0;
    if (secs[MAG_W-1:0] < len) begin
      slot = wheel_pos + 1'b1;
      return 1'b1;
    end
    ticks = secs[MAG_W-1:0] / len;
    slot = wheel_pos + ticks[SLOT_W-1:0];
    turns = ticks[MAG_W-1:SLOT_W];
    return 1'b1;
  endfunction

  // append one expected word at the tail of the queue
  function automatic void add_reply(input reply_t r);
    due_replies = {due_replies, r};
  endfunction

  function automatic void predict_wheel(input word_t w);
    logic [SLOT_W-1:0]  slot;
    logic [TURNS_W-1:0] turns;
    int                 free_h;
    bit                 ok;
    case (w.op)
      OP_INSERT: begin
        free_h = -1;
        if (place_timer(w.secs, slot, turns))
          for (int i = TIMERS - 1; i >= 0; i--)
            if (!live[i]) free_h = i;
        if (free_h >= 0) begin
          live[free_h] = 1'b1;
          slot_of[free_h] = slot;
          turns_of[free_h] = turns;
          add_reply(reply_t'{K_INSERT, 1'b0, ID_W'(free_h), 1'b1});
        end else begin
          add_reply(reply_t'{K_INSERT, 1'b1, ID_W'(0), 1'b1});
        end
      end
      OP_REMOVE: begin
        ok = live[w.id];
        live[w.id] = 1'b0;
        add_reply(reply_t'{K_REMOVE, !ok, w.id, 1'b1});
      end
      OP_ADJUST: begin
        ok = live[w.id];
        if (ok) ok = place_timer(w.secs, slot, turns);
        if (ok) begin
          slot_of[w.id] = slot;
          turns_of[w.id] = turns;
        end
        add_reply(reply_t'{K_ADJUST, !ok, w.id, 1'b1});
      end
      OP_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (live[i] && slot_of[i] == wheel_pos) begin
            if (turns_of[i] != '0) begin
              turns_of[i] = turns_of[i] - 1'b1;
            end else begin
              live[i] = 1'b0;
              add_reply(reply_t'{K_EXPIRED, 1'b0, ID_W'(i), 1'b0});
            end
          end
        end
        wheel_pos = wheel_pos + 1'b1;
        add_reply(reply_t'{K_DONE, 1'b0, ID_W'(0), 1'b1});
      end
    endcase
  endfunction

  function automatic void log_fault(input string msg);
    if (fault_count < 10) $display("mismatch: %s", msg);
    fault_count++;
  endfunction

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(input word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= w.op;
    timer_id <= w.id;
    timeout_seconds <= w.secs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_wheel(w);
    if (w.typed) begin
      void'(due_replies.pop_back());
      add_reply(w.reply);
    end
  endtask

  task automatic send_random_word();
    word_t           w;
    logic [TS_W-1:0] len;
    int              pick;
    int              start;
    w = '0;
    len = (tick_len == '0) ? TS_W'(1) : tick_len;
    pick = $urandom_range(99);
    w.op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_TICK : (pick < 82) ? OP_REMOVE : OP_ADJUST;
    start = $urandom_range(TIMERS - 1);
    w.id = ID_W'(start);
    // mostly aim remove and adjust at a live timer
    if ($urandom_range(3) != 0)
      for (int k = TIMERS - 1; k >= 0; k--)
        if (live[(start + k) % TIMERS]) w.id = ID_W'((start + k) % TIMERS);
    case ($urandom_range(9))
      0:       w.secs = TO_W'($urandom);
      1:       w.secs = TO_W'($urandom_range(len - 1));
      default: w.secs = TO_W'($urandom_range(len * WHEEL_SLOTS * 2));
    endcase
    send_word(w);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tick_len(input logic [TS_W-1:0] v);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_data <= v;
    tick_len = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (due_replies.size() == 0) begin
        log_fault($sformatf("unexpected kind %0d status %0d handle %0d last %0d",
                            kind, status, handle, last));
      end else begin
        want = due_replies.pop_front();
        if (kind !== want.kind || status !== want.status || handle !== want.handle ||
            last !== want.last)
          log_fault($sformatf({"expected kind %0d status %0d handle %0d last %0d, ",
                               "got kind %0d status %0d handle %0d last %0d"},
                              want.kind, want.status, want.handle, want.last,
                              kind, status, handle, last));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_idle);
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= OP_INSERT;
    timer_id <= '0;
    timeout_seconds <= '0;
    out_stall <= 1'b0;
    fault_count = 0;
    send_idle = 35;
    recv_idle = 82;
    for (int i = 0; i < TIMERS; i++) live[i] = 1'b0;
    wheel_pos = '0;
    tick_len = TICK_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) send_word(dir_table[r]);

    // zero length counts as one second
    write_tick_len('0);
    repeat (ROUND_WORDS) send_random_word();

    send_idle = 82;
    recv_idle = 35;
    write_tick_len('1);
    repeat (ROUND_WORDS) send_random_word();

    send_idle = 0;
    recv_idle = 0;
    write_tick_len(TS_W'($urandom_range(12, 2)));
    // fill the pool past full, all due next slot, then expire them in one tick
    repeat (TIMERS + 1) send_word('{OP_INSERT, ID_W'(0), TO_W'(0), 1'b0, '0});
    repeat (2) send_word('{OP_TICK, ID_W'(0), TO_W'(0), 1'b0, '0});
    repeat (ROUND_WORDS) send_random_word();

    write_tick_len(TS_W'(3600));
    repeat (ROUND_WORDS) send_random_word();

    wait_quiet();
    repeat (60) @(posedge clk);
    if (fault_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
